// File: sv/pedt_pkg.sv
// ============================================================================
// pedt_pkg - shared types and constants for the event deadline table
// Request codes, result codes, controller states and the wait unit scale.
// ============================================================================
package pedt_pkg;

    // Request codes carried on the action field
    typedef enum logic [2:0] {
        ACT_SCHEDULE   = 3'd0,
        ACT_REMOVE     = 3'd1,
        ACT_REMOVE_ALL = 3'd2,
        ACT_FLUSH      = 3'd3,
        ACT_PAUSE      = 3'd4,
        ACT_UNPAUSE    = 3'd5,
        ACT_TICK       = 3'd6
    } action_t;

    // Result codes carried on the kind field
    typedef enum logic [2:0] {
        KIND_FIRED     = 3'd0,
        KIND_ACCEPTED  = 3'd1,
        KIND_FULL      = 3'd2,
        KIND_REMOVED   = 3'd3,
        KIND_NOT_FOUND = 3'd4,
        KIND_DONE      = 3'd5
    } kind_t;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_FLUSH  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    localparam int DEADLINE_W = 64;
    localparam int SCALE_W    = 30;
    localparam int WAIT_W     = 32;
    localparam int PRODUCT_W  = WAIT_W + SCALE_W;

    localparam logic [1:0] UNIT_NS = 2'd0;
    localparam logic [1:0] UNIT_US = 2'd1;
    localparam logic [1:0] UNIT_MS = 2'd2;
    localparam logic [1:0] UNIT_S  = 2'd3;

    // Nanoseconds per wait unit
    function automatic logic [SCALE_W-1:0] unit_scale(input logic [1:0] u);
        logic [SCALE_W-1:0] s;
        case (u)
            UNIT_NS: s = SCALE_W'(1);
            UNIT_US: s = SCALE_W'(1000);
            UNIT_MS: s = SCALE_W'(1000000);
            UNIT_S:  s = SCALE_W'(1000000000);
            default: s = SCALE_W'(1);
        endcase
        return s;
    endfunction

endpackage

// File: sv/pedt_cell.sv
// ============================================================================
// pedt_cell - one slot of the event table
// Holds a deadline and a tag; loads a new entry or takes its upper neighbor's.
// ============================================================================
module pedt_cell
    import pedt_pkg::*;
#(
    parameter int TW = 16
)
(
    input  logic                  clk,
    input  logic                  shift,
    input  logic                  load,
    input  logic [DEADLINE_W-1:0] shift_deadline,
    input  logic [TW-1:0]         shift_tag,
    input  logic [DEADLINE_W-1:0] load_deadline,
    input  logic [TW-1:0]         load_tag,
    output logic [DEADLINE_W-1:0] deadline,
    output logic [TW-1:0]         tag
);

    logic [DEADLINE_W-1:0] deadline_reg;
    logic [TW-1:0]         tag_reg;

    // Load a new entry, else advance the neighbor's entry down
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            deadline_reg <= load_deadline;
            tag_reg      <= load_tag;
        end
        else if (shift)
        begin
            deadline_reg <= shift_deadline;
            tag_reg      <= shift_tag;
        end
    end

    assign deadline = deadline_reg;
    assign tag      = tag_reg;

endmodule

// File: sv/pedt_chain.sv
// ============================================================================
// pedt_chain - row of table cells
// Shifts entries toward the head and writes one entry at a chosen slot.
// ============================================================================
module pedt_chain
    import pedt_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int TW    = 16,
    parameter int IW    = 4
)
(
    input  logic                  clk,
    input  logic                  shift,
    input  logic                  load,
    input  logic [IW-1:0]         load_idx,
    input  logic [DEADLINE_W-1:0] load_deadline,
    input  logic [TW-1:0]         load_tag,
    output logic [DEADLINE_W-1:0] head_deadline,
    output logic [TW-1:0]         head_tag
);

    logic [DEADLINE_W-1:0] link_deadline [SLOTS+1];
    logic [TW-1:0]         link_tag      [SLOTS+1];

    // Feed the top cell with a blank entry
    assign link_deadline[SLOTS] = '0;
    assign link_tag[SLOTS]      = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        pedt_cell #(
            .TW (TW)
        ) u_cell (
            .clk            (clk),
            .shift          (shift),
            .load           (load && (load_idx == IW'(i))),
            .shift_deadline (link_deadline[i+1]),
            .shift_tag      (link_tag[i+1]),
            .load_deadline  (load_deadline),
            .load_tag       (load_tag),
            .deadline       (link_deadline[i]),
            .tag            (link_tag[i])
        );
    end

    assign head_deadline = link_deadline[0];
    assign head_tag      = link_tag[0];

endmodule

// File: sv/pausable_event_deadline_table.sv
// ============================================================================
// pausable_event_deadline_table - table of pending timed events
// Schedules, removes, pauses and fires events kept in insertion order.
// ============================================================================
// The table is a row of SLOTS cells kept packed from the head in insertion
// order. Requests are taken one at a time. Schedule goes through capture,
// multiply of the wait by its unit, and write. Pause, unpause, flush, remove
// all and a paused tick go through capture and finish only. Remove and an
// unpaused tick stream every stored entry past the head cell, one entry a
// cycle unless a fired result stalls the pass; a tick that honors a pending
// flush then fires and drops each entry left after the deadline pass, and
// then finishes the flush.
// Every fired, removed or final result goes through a one-entry output
// register, and the pass stalls when a new result finds the one there not taken.
module pausable_event_deadline_table
    import pedt_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int TAG_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [1:0]  unit,
    input  logic [31:0] wait_time,
    input  logic [15:0] event_tag,
    input  logic [62:0] now_ns,
    input  logic [31:0] frame_delta_ns,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [15:0] fired_tag,
    output logic        is_paused,
    output logic        last
);

    localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Control state
    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic [DEADLINE_W-1:0] pause_total_reg, pause_total_next;
    logic                  paused_reg, paused_next;
    logic                  flush_reg, flush_next;
    logic                  found_reg, found_next;
    logic                  out_valid_reg, out_valid_next;

    // Request and datapath registers
    action_t               act_reg;
    logic [1:0]            unit_reg;
    logic [WAIT_W-1:0]     wait_reg;
    logic [TW-1:0]         tag_reg;
    logic [62:0]           now_reg;
    logic [31:0]           delta_reg;
    logic [PRODUCT_W-1:0]  product_reg, product_next;
    logic [DEADLINE_W-1:0] base_reg, base_next;
    kind_t                 kind_reg, kind_next;
    logic [15:0]           tag_out_reg, tag_out_next;
    logic                  paused_out_reg, paused_out_next;
    logic                  last_reg, last_next;

    // Chain control
    logic                  chain_shift;
    logic                  chain_load;
    logic [IW-1:0]         chain_idx;
    logic [DEADLINE_W-1:0] chain_deadline;
    logic [TW-1:0]         chain_tag;
    logic [DEADLINE_W-1:0] head_deadline;
    logic [TW-1:0]         head_tag;

    logic in_fire;
    logic out_free;
    logic is_tick;
    logic fire_hit;
    logic tag_hit;
    logic drop;
    logic emit;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Head cell tests
    assign is_tick  = (act_reg == ACT_TICK);
    assign fire_hit = (head_deadline + pause_total_reg) <= {1'b0, now_reg};
    assign tag_hit  = (head_tag == tag_reg);
    assign drop     = is_tick ? fire_hit : (!found_reg && tag_hit);
    assign emit     = is_tick && fire_hit;

    pedt_chain #(
        .SLOTS (SLOTS),
        .TW    (TW),
        .IW    (IW)
    ) u_chain (
        .clk           (clk),
        .shift         (chain_shift),
        .load          (chain_load),
        .load_idx      (chain_idx),
        .load_deadline (chain_deadline),
        .load_tag      (chain_tag),
        .head_deadline (head_deadline),
        .head_tag      (head_tag)
    );

    // Sequence requests and drive the chain
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        rem_next         = rem_reg;
        pause_total_next = pause_total_reg;
        paused_next      = paused_reg;
        flush_next       = flush_reg;
        found_next       = found_reg;
        product_next     = product_reg;
        base_next        = base_reg;
        kind_next        = kind_reg;
        tag_out_next     = tag_out_reg;
        paused_out_next  = paused_out_reg;
        last_next        = last_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        chain_shift      = 1'b0;
        chain_load       = 1'b0;
        chain_idx        = IW'(count_reg);
        chain_deadline   = base_reg + DEADLINE_W'(product_reg);
        chain_tag        = tag_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rem_next   = count_reg;
                    found_next = 1'b0;
                    case (action_t'(action))
                        ACT_SCHEDULE: state_next = ST_MUL;
                        ACT_REMOVE:   state_next = ST_SCAN;
                        ACT_TICK:     state_next = paused_reg ? ST_FINISH : ST_SCAN;
                        default:      state_next = ST_FINISH;
                    endcase
                end
            end

            ST_MUL:
            begin
                product_next = wait_reg * unit_scale(unit_reg);
                base_next    = {1'b0, now_reg} - pause_total_reg;
                state_next   = ST_FINISH;
            end

            ST_SCAN:
            begin
                if (rem_reg == '0)
                begin
                    state_next = (is_tick && flush_reg) ? ST_FLUSH : ST_FINISH;
                end
                else if (!emit || out_free)
                begin
                    // Pop the head; requeue it at the tail unless dropped
                    chain_shift = 1'b1;
                    rem_next    = rem_reg - CW'(1);
                    if (drop)
                    begin
                        count_next = count_reg - CW'(1);
                        if (!is_tick)
                        begin
                            found_next = 1'b1;
                        end
                    end
                    else
                    begin
                        chain_load     = 1'b1;
                        chain_idx      = IW'(count_reg - CW'(1));
                        chain_deadline = head_deadline;
                        chain_tag      = head_tag;
                    end
                    if (emit)
                    begin
                        out_valid_next  = 1'b1;
                        kind_next       = KIND_FIRED;
                        tag_out_next    = 16'(head_tag);
                        paused_out_next = paused_reg;
                        last_next       = 1'b0;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (out_free)
                begin
                    // Fire the head and drop it
                    chain_shift     = 1'b1;
                    count_next      = count_reg - CW'(1);
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_FIRED;
                    tag_out_next    = 16'(head_tag);
                    paused_out_next = paused_reg;
                    last_next       = 1'b0;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    last_next       = 1'b1;
                    kind_next       = KIND_DONE;
                    tag_out_next    = '0;
                    paused_out_next = paused_reg;
                    state_next      = ST_IDLE;
                    case (act_reg)
                        ACT_SCHEDULE:
                        begin
                            tag_out_next = 16'(tag_reg);
                            if (count_reg >= CW'(SLOTS))
                            begin
                                kind_next = KIND_FULL;
                            end
                            else
                            begin
                                chain_load = 1'b1;
                                count_next = count_reg + CW'(1);
                                kind_next  = KIND_ACCEPTED;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            tag_out_next = 16'(tag_reg);
                            kind_next    = found_reg ? KIND_REMOVED : KIND_NOT_FOUND;
                        end
                        ACT_REMOVE_ALL:
                        begin
                            count_next = '0;
                        end
                        ACT_FLUSH:
                        begin
                            flush_next = 1'b1;
                        end
                        ACT_PAUSE:
                        begin
                            paused_next     = 1'b1;
                            paused_out_next = 1'b1;
                        end
                        ACT_UNPAUSE:
                        begin
                            paused_next     = 1'b0;
                            paused_out_next = 1'b0;
                        end
                        ACT_TICK:
                        begin
                            if (paused_reg)
                            begin
                                pause_total_next = pause_total_reg + DEADLINE_W'(delta_reg);
                            end
                            else
                            begin
                                flush_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            kind_next = KIND_DONE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            rem_reg         <= '0;
            pause_total_reg <= '0;
            paused_reg      <= 1'b0;
            flush_reg       <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            rem_reg         <= rem_next;
            pause_total_reg <= pause_total_next;
            paused_reg      <= paused_next;
            flush_reg       <= flush_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Capture the request fields
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg   <= action_t'(action);
            unit_reg  <= unit;
            wait_reg  <= wait_time;
            tag_reg   <= TW'(event_tag);
            now_reg   <= now_ns;
            delta_reg <= frame_delta_ns;
        end
    end

    // Hold datapath and result payload
    always_ff @(posedge clk)
    begin
        product_reg    <= product_next;
        base_reg       <= base_next;
        kind_reg       <= kind_next;
        tag_out_reg    <= tag_out_next;
        paused_out_reg <= paused_out_next;
        last_reg       <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign fired_tag = tag_out_reg;
    assign is_paused = paused_out_reg;
    assign last      = last_reg;

endmodule
